// ===== sv/ple_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int ACT_W    = 2;
   localparam int POS_W    = 7;
   localparam int STAT_W   = 2;
   localparam int LEN_W    = 7;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_GET    = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] value_out;
      logic [LEN_W-1:0]         length;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_FLUSH,
      S_PLACE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/ple_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ple_store (
   input  wire logic                     clock,
   input  wire ple_pkg::mem_req_type     mem_req,
   output logic [ple_pkg::DATA_W-1:0]    rd_data
);

   logic [ple_pkg::DATA_W-1:0] mem [ple_pkg::CAPACITY];
   logic [ple_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ple_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ple_pkg::req_type         req_payload,
   input  wire logic                     rsp_free,
   output logic                          rsp_load,
   output ple_pkg::rsp_type              rsp_next,
   output ple_pkg::mem_req_type          mem_req,
   input  wire logic [ple_pkg::DATA_W-1:0] rd_data
);

   ple_pkg::state_type state_ff, state_in;

   logic [ple_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ple_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [ple_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [ple_pkg::DATA_W-1:0] val_ff, val_in;
   logic [ple_pkg::ADDR_W-1:0] cur_ff, cur_in;
   logic [ple_pkg::ADDR_W-1:0] end_ff, end_in;
   logic [ple_pkg::ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic                       up_ff, up_in;
   logic                       first_ff, first_in;
   logic                       pend_ff, pend_in;
   logic                       cap_ff, cap_in;
   logic [ple_pkg::DATA_W-1:0] result_ff, result_in;
   logic [ple_pkg::STAT_W-1:0] status_ff, status_in;

   logic [ple_pkg::CMP_W-1:0]  pos_x;
   logic [ple_pkg::CMP_W-1:0]  cnt_x;
   logic                       pos_nz;
   logic                       ok_ins;
   logic                       ok_rd;
   logic                       full;
   logic [ple_pkg::ADDR_W-1:0] p0;
   logic [ple_pkg::ADDR_W-1:0] last;
   logic [ple_pkg::ADDR_W-1:0] step_fwd;
   logic [ple_pkg::ADDR_W-1:0] step_back;

   // position checks against the current fill
   assign pos_x  = ple_pkg::CMP_W'(pos_ff);
   assign cnt_x  = ple_pkg::CMP_W'(count_ff);
   assign pos_nz = (pos_ff != '0);
   assign ok_ins = pos_nz && (pos_x <= cnt_x + ple_pkg::CMP_W'(1));
   assign ok_rd  = pos_nz && (pos_x <= cnt_x);
   assign full   = (cnt_x >= ple_pkg::CMP_W'(ple_pkg::CAPACITY));
   assign p0     = ple_pkg::ADDR_W'(pos_ff - ple_pkg::POS_W'(1));
   assign last   = ple_pkg::ADDR_W'(count_ff - ple_pkg::CNT_W'(1));

   // shared address stepper: walk down for insert, up for delete and get
   assign step_fwd  = up_ff ? cur_ff - ple_pkg::ADDR_W'(1) : cur_ff + ple_pkg::ADDR_W'(1);
   assign step_back = up_ff ? cur_ff + ple_pkg::ADDR_W'(1) : cur_ff - ple_pkg::ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      cur_ff     <= cur_in;
      end_ff     <= end_in;
      wr_addr_ff <= wr_addr_in;
      up_ff      <= up_in;
      first_ff   <= first_in;
      cap_ff     <= cap_in;
      result_ff  <= result_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      act_in     = act_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      cur_in     = cur_ff;
      end_in     = end_ff;
      wr_addr_in = wr_addr_ff;
      up_in      = up_ff;
      first_in   = first_ff;
      pend_in    = 1'b0;
      cap_in     = 1'b0;
      result_in  = result_ff;
      status_in  = status_ff;
      mem_req    = '0;
      req_stall  = 1'b1;
      rsp_load   = 1'b0;

      // retire the read issued last cycle: keep it as the result or move it
      if (pend_ff) begin
         if (cap_ff) begin
            result_in = rd_data;
         end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_addr_ff;
            mem_req.wr_data = rd_data;
         end
      end

      unique case (state_ff)
         ple_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               act_in    = req_payload.action;
               pos_in    = req_payload.position;
               val_in    = req_payload.value_in;
               result_in = '0;
               state_in  = ple_pkg::S_DECODE;
            end
         end
         ple_pkg::S_DECODE: begin
            status_in = ple_pkg::STAT_RANGE;
            state_in  = ple_pkg::S_DONE;
            priority if (act_ff == ple_pkg::ACT_INSERT) begin
               if (ok_ins) begin
                  if (full) begin
                     status_in = ple_pkg::STAT_FULL;
                  end else if (pos_x == cnt_x + ple_pkg::CMP_W'(1)) begin
                     state_in = ple_pkg::S_PLACE;
                  end else begin
                     cur_in   = last;
                     end_in   = p0;
                     up_in    = 1'b1;
                     first_in = 1'b0;
                     state_in = ple_pkg::S_SHIFT;
                  end
               end
            end else if (act_ff == ple_pkg::ACT_DELETE || act_ff == ple_pkg::ACT_GET) begin
               if (ok_rd) begin
                  cur_in   = p0;
                  end_in   = (act_ff == ple_pkg::ACT_DELETE) ? last : p0;
                  up_in    = 1'b0;
                  first_in = 1'b1;
                  state_in = ple_pkg::S_SHIFT;
               end
            end else begin
               status_in = ple_pkg::STAT_RANGE;
            end
         end
         ple_pkg::S_SHIFT: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cur_ff;
            pend_in         = 1'b1;
            cap_in          = first_ff;
            first_in        = 1'b0;
            wr_addr_in      = step_back;
            if (cur_ff == end_ff) begin
               state_in = ple_pkg::S_FLUSH;
            end else begin
               cur_in = step_fwd;
            end
         end
         ple_pkg::S_FLUSH: begin
            status_in = ple_pkg::STAT_OK;
            if (act_ff == ple_pkg::ACT_INSERT) begin
               state_in = ple_pkg::S_PLACE;
            end else begin
               if (act_ff == ple_pkg::ACT_DELETE) begin
                  count_in = count_ff - ple_pkg::CNT_W'(1);
               end
               state_in = ple_pkg::S_DONE;
            end
         end
         ple_pkg::S_PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = p0;
            mem_req.wr_data = val_ff;
            count_in        = count_ff + ple_pkg::CNT_W'(1);
            status_in       = ple_pkg::STAT_OK;
            state_in        = ple_pkg::S_DONE;
         end
         ple_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ple_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_next.status    = status_ff;
   assign rsp_next.value_out = result_ff;
   assign rsp_next.length    = ple_pkg::LEN_W'(count_ff);

endmodule

`default_nettype wire

// ===== sv/positional_list_engine_unit.sv =====
// Path per request: decode; a rejected request goes straight to the result, an insert at length + 1
//   goes straight to the place step; other inserts and deletes shift the elements from position to
//   the end, a get reads one element, each through the shift loop and a flush step; inserts then place.
// Throughput: one request at a time; the next is taken once the result is in the output
//   register. The rate is set by the shift loop, one element per cycle on the store's ports.
// Reset (synchronous, active high) empties the list and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ple_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ple_pkg::rsp_type      rsp_payload
);

   ple_pkg::mem_req_type       mem_req;
   logic [ple_pkg::DATA_W-1:0] rd_data;
   ple_pkg::rsp_type           rsp_next;
   logic                       rsp_load;
   logic                       rsp_free;

   logic                       rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // element storage: one read and one write port, registered read data
   ple_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // sequencer: decode, shift elements one place a cycle, place or retire, report
   ple_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .rsp_next    (rsp_next),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   // output register: free when empty or when its beat leaves this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         // load the finished result
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (!rsp_stall) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ===== sv/ple_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ple_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ple_pkg::rsp_type rsp_payload
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat dropped or changed while stalled");

   // one request at a time: stall right after a request beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in progress");

   // failed requests return zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ple_pkg::STAT_OK |-> rsp_payload.value_out == '0)
      else $error("nonzero value on failed request");

   // length never exceeds the capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.length <= ple_pkg::LEN_W'(ple_pkg::CAPACITY))
      else $error("length beyond capacity");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ple_pkg::*;

   // Action code three is unused by the block and must be rejected.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   localparam int RESET_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_ITEMS  = 1530;
   localparam int PHASE_ITEMS   = 510;
   localparam int CHUNK_ITEMS   = 100;
   // Leave room after the longest request for stray beats.
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 20;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef enum int {
      MODE_GROW,
      MODE_MIXED,
      MODE_SHRINK
   } churn_mode_type;

   // One directed row: the request, and where obvious, the typed-in answer.
   typedef struct {
      req_type beat;
      bit      has_answer;
      rsp_type answer;
   } list_case_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the sequence held by the block.
   logic signed [DATA_W-1:0] shadow_elems [CAPACITY];
   int                       shadow_count = 0;

   // Answers still owed by the block, oldest first.
   rsp_type       predicted_replies [$];
   rsp_type       oldest_reply;
   list_case_type script [DIRECTED_ROWS];

   int error_count   = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   positional_list_engine_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Apply one request to the shadow sequence and return the answer it earns.
   function automatic rsp_type apply_list_request(input req_type beat);
      rsp_type reply;
      int      pos;
      reply.status    = STAT_RANGE;
      reply.value_out = '0;
      pos             = int'(beat.position);
      case (beat.action)
         ACT_INSERT: begin
            if (pos >= 1 && pos <= shadow_count + 1) begin
               if (shadow_count >= CAPACITY) begin
                  reply.status = STAT_FULL;
               end else begin
                  // open a slot: move everything from pos upward by one
                  for (int k = shadow_count; k > pos - 1; k--) begin
                     shadow_elems[k] = shadow_elems[k - 1];
                  end
                  shadow_elems[pos - 1] = beat.value_in;
                  shadow_count++;
                  reply.status = STAT_OK;
               end
            end
         end
         ACT_DELETE: begin
            if (pos >= 1 && pos <= shadow_count) begin
               reply.value_out = shadow_elems[pos - 1];
               // close the gap left behind
               for (int k = pos - 1; k + 1 < shadow_count; k++) begin
                  shadow_elems[k] = shadow_elems[k + 1];
               end
               shadow_count--;
               reply.status = STAT_OK;
            end
         end
         ACT_GET: begin
            if (pos >= 1 && pos <= shadow_count) begin
               reply.value_out = shadow_elems[pos - 1];
               reply.status    = STAT_OK;
            end
         end
         default: begin
         end
      endcase
      reply.length = LEN_W'(shadow_count);
      return reply;
   endfunction

   function automatic list_case_type make_row(input logic [ACT_W-1:0] act,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DATA_W-1:0] val,
                                              input bit has_answer,
                                              input logic [STAT_W-1:0] st,
                                              input logic [DATA_W-1:0] vo,
                                              input logic [LEN_W-1:0] len);
      list_case_type row;
      row.beat.action      = act;
      row.beat.position    = pos;
      row.beat.value_in    = val;
      row.has_answer       = has_answer;
      row.answer.status    = st;
      row.answer.value_out = vo;
      row.answer.length    = len;
      return row;
   endfunction

   // Random request; the mode steers the mix so the list fills, churns or empties.
   function automatic req_type random_request(input churn_mode_type mode);
      req_type beat;
      int      roll;
      int      ins_pct;
      int      del_pct;
      int      hi;
      case (mode)
         MODE_GROW: begin
            ins_pct = 80;
            del_pct = 10;
         end
         MODE_SHRINK: begin
            ins_pct = 15;
            del_pct = 70;
         end
         default: begin
            ins_pct = 40;
            del_pct = 30;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
         beat.action = ACT_INSERT;
      end else if (roll < ins_pct + del_pct) begin
         beat.action = ACT_DELETE;
      end else if (roll < 98) begin
         beat.action = ACT_GET;
      end else begin
         beat.action = ACT_UNUSED;
      end

      // mostly legal positions, with edges and raw noise mixed in
      hi   = (beat.action == ACT_INSERT) ? shadow_count + 1
                                         : ((shadow_count == 0) ? 1 : shadow_count);
      roll = $urandom_range(99);
      if (roll < 12) begin
         beat.position = POS_W'($urandom_range(127));
      end else if (roll < 30) begin
         case ($urandom_range(3))
            0:       beat.position = '0;
            1:       beat.position = POS_W'(1);
            2:       beat.position = POS_W'(shadow_count);
            default: beat.position = POS_W'(shadow_count + 1);
         endcase
      end else begin
         beat.position = POS_W'($urandom_range(hi, 1));
      end

      roll = $urandom_range(99);
      if (roll < 10) begin
         case ($urandom_range(3))
            0:       beat.value_in = 32'h7fff_ffff;
            1:       beat.value_in = 32'h8000_0000;
            2:       beat.value_in = 32'h0000_0000;
            default: beat.value_in = 32'hffff_ffff;
         endcase
      end else begin
         beat.value_in = $urandom;
      end
      return beat;
   endfunction

   // Present one beat after a random gap, hold it until taken, then log the answer.
   task automatic issue_request(input req_type beat, input bit has_answer,
                                input rsp_type answer);
      rsp_type reply;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      // accepted at this edge: advance the shadow state regardless
      reply = apply_list_request(beat);
      predicted_replies.push_back(has_answer ? answer : reply);
   endtask

   // Drop valid and hold off until every owed answer has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_replies.size() != 0);
   endtask

   task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check each taken result beat against the oldest owed answer.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (predicted_replies.size() == 0) begin
            $display("%0t: result beat with nothing owed, actual status %0h value %0h length %0h",
                     $time, rsp_payload.status, rsp_payload.value_out, rsp_payload.length);
            error_count++;
         end else begin
            oldest_reply = predicted_replies.pop_front();
            compare_field("status", DATA_W'(oldest_reply.status), DATA_W'(rsp_payload.status));
            compare_field("value_out", oldest_reply.value_out, rsp_payload.value_out);
            compare_field("length", DATA_W'(oldest_reply.length), DATA_W'(rsp_payload.length));
         end
      end
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_list_engine_unit regression: fail");
         $finish;
      end
   end

   initial begin
      // empty list: every read, delete, bad insert and the unused action code is out of range
      script[0]  = make_row(ACT_GET,    7'd1,   32'h0,         1, STAT_RANGE, 32'h0, 7'd0);
      script[1]  = make_row(ACT_DELETE, 7'd1,   32'h0,         1, STAT_RANGE, 32'h0, 7'd0);
      script[2]  = make_row(ACT_INSERT, 7'd0,   32'h5,         1, STAT_RANGE, 32'h0, 7'd0);
      script[3]  = make_row(ACT_INSERT, 7'd2,   32'h5,         1, STAT_RANGE, 32'h0, 7'd0);
      script[4]  = make_row(ACT_UNUSED, 7'd1,   32'h0,         1, STAT_RANGE, 32'h0, 7'd0);
      // build max, min, -1 in front/back order
      script[5]  = make_row(ACT_INSERT, 7'd1,   32'h7fff_ffff, 1, STAT_OK,    32'h0, 7'd1);
      script[6]  = make_row(ACT_INSERT, 7'd1,   32'h8000_0000, 1, STAT_OK,    32'h0, 7'd2);
      script[7]  = make_row(ACT_INSERT, 7'd3,   32'hffff_ffff, 1, STAT_OK,    32'h0, 7'd3);
      script[8]  = make_row(ACT_GET,    7'd1,   32'h0,   1, STAT_OK, 32'h8000_0000, 7'd3);
      script[9]  = make_row(ACT_GET,    7'd3,   32'h0,   1, STAT_OK, 32'hffff_ffff, 7'd3);
      // just past the end, and the largest position code; then a delete from the middle
      script[10] = make_row(ACT_GET,    7'd4,   32'h0,         1, STAT_RANGE, 32'h0, 7'd3);
      script[11] = make_row(ACT_GET,    7'd127, 32'h0,         1, STAT_RANGE, 32'h0, 7'd3);
      script[12] = make_row(ACT_INSERT, 7'd127, 32'h1,         1, STAT_RANGE, 32'h0, 7'd3);
      script[13] = make_row(ACT_DELETE, 7'd127, 32'h0,         1, STAT_RANGE, 32'h0, 7'd3);
      script[14] = make_row(ACT_UNUSED, 7'd127, 32'hffff_ffff, 1, STAT_RANGE, 32'h0, 7'd3);
      script[15] = make_row(ACT_DELETE, 7'd2,   32'h0,   1, STAT_OK, 32'h7fff_ffff, 7'd2);
      // from here on the predictor supplies the answers
      script[16] = make_row(ACT_INSERT, 7'd2,   32'h0000_0000, 0, STAT_OK, 32'h0, 7'd0);
      script[17] = make_row(ACT_INSERT, 7'd2,   32'h1234_5678, 0, STAT_OK, 32'h0, 7'd0);
      script[18] = make_row(ACT_DELETE, 7'd1,   32'hdead_beef, 0, STAT_OK, 32'h0, 7'd0);
      script[19] = make_row(ACT_GET,    7'd2,   32'h0,         0, STAT_OK, 32'h0, 7'd0);
      script[20] = make_row(ACT_DELETE, 7'd3,   32'h0,         0, STAT_OK, 32'h0, 7'd0);
      script[21] = make_row(ACT_GET,    7'd0,   32'hffff_ffff, 0, STAT_OK, 32'h0, 7'd0);

      // hold reset, then release it on an edge
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender idles lightly, receiver heavily
      send_idle_pct = 30;
      recv_idle_pct = 60;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         issue_request(script[i].beat, script[i].has_answer, script[i].answer);
      end
      drain_replies();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swap the idle ratios, then stop idling; drain at each switch
         if (n == PHASE_ITEMS) begin
            drain_replies();
            send_idle_pct = 60;
            recv_idle_pct = 30;
         end else if (n == 2 * PHASE_ITEMS) begin
            drain_replies();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         issue_request(random_request(churn_mode_type'((n / CHUNK_ITEMS) % 3)), 1'b0, '0);
      end

      // wait for the tail, then watch a while for stray beats
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("positional_list_engine_unit regression: pass");
      end else begin
         $display("positional_list_engine_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ple_pkg.sv
sv/ple_store.sv
sv/ple_ctrl.sv
sv/positional_list_engine_unit.sv
sv/ple_checker.sv
sim/tb_top.sv
